// ----- hdl/cda_pkg.sv -----
// Shared types, constants and calendar functions of the date counter.
package cda_pkg;

  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned DoyW   = 9;
  localparam int unsigned RemW   = 5;
  localparam int unsigned FoldW  = 13;

  localparam logic [MonthW-1:0] MonthJan = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;
  localparam logic [DayW-1:0]   DayFirst = 5'd1;
  localparam logic [RemW-1:0]   Rem24    = 5'd24;
  // a multiple of 25 that keeps the first fold of the year positive
  localparam logic [FoldW-1:0]  FoldBias = 13'd2050;
  localparam logic [DoyW-1:0]   YearLen     = 9'd365;
  localparam logic [DoyW-1:0]   LeapYearLen = 9'd366;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // take a new date, start the year remainder
    logic adv_start; // take the day count of an advance
    logic mod_step;  // one step of year mod 25
    logic clamp;     // fit the loaded day into its month
    logic adv_step;  // one month of advance
    logic capture;   // latch the result word
  } cda_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mod_last;  // last remainder step in this cycle
    logic adv_last;  // remaining days fit in the current month
  } cda_sts_t;

  // Leap year from the year's remainder modulo 25 and its low four bits:
  // a century year is leap only when it is also a multiple of 16.
  function automatic logic leap_of_rem(input logic [RemW-1:0] rem,
                                       input logic [3:0] y_lo);
    return (y_lo[1:0] == 2'd0) && ((rem != '0) || (y_lo == 4'd0));
  endfunction

  // Remainder modulo 25 of a byte by compare and subtract.
  function automatic logic [RemW-1:0] mod25_byte(input logic [7:0] v);
    logic [7:0] r;
    r = v;
    if (r >= 8'd200) r = r - 8'd200;
    if (r >= 8'd100) r = r - 8'd100;
    if (r >= 8'd50)  r = r - 8'd50;
    if (r >= 8'd25)  r = r - 8'd25;
    return r[RemW-1:0];
  endfunction

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                input logic leap);
    logic [DayW-1:0] len;
    case (m) inside
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      MonthFeb:                len = leap ? 5'd29 : 5'd28;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

  // Days in the months before m in a common year.
  function automatic logic [DoyW-1:0] days_before(input logic [MonthW-1:0] m);
    logic [DoyW-1:0] d;
    case (m)
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// ----- hdl/cda_datapath.sv -----
// Datapath of the date counter: date registers, year remainder unit, result word.
module cda_datapath
  import cda_pkg::*;
#(
  parameter int unsigned YEAR_BITS    = 16,
  parameter int unsigned ADVANCE_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cda_cmd_t                     cmd_i,
  output cda_sts_t                     sts_o,
  input  logic [MonthW-1:0]            load_month_i,
  input  logic [DayW-1:0]              load_day_i,
  input  logic [YEAR_BITS-1:0]         load_year_i,
  input  logic [ADVANCE_BITS-1:0]      advance_days_i,
  output logic [MonthW-1:0]            cur_month_o,
  output logic [DayW-1:0]              cur_day_o,
  output logic [YEAR_BITS-1:0]         cur_year_o,
  output logic                         leap_flag_o,
  output logic [DoyW-1:0]              day_of_year_o,
  output logic [DoyW-1:0]              days_left_o
);

  localparam int unsigned CntW = 2;
  localparam logic [CntW-1:0] CntStart = 2'd2;

  logic [MonthW-1:0]       month_q, month_d;
  logic [DayW-1:0]         day_q, day_d;
  logic [YEAR_BITS-1:0]    year_q, year_d;
  logic [RemW-1:0]         rem_q, rem_d;
  logic [FoldW-1:0]        fold_q, fold_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic [ADVANCE_BITS-1:0] n_q, n_d;

  logic                    leap;
  logic [DayW-1:0]         mlen;
  logic [DayW-1:0]         room;
  logic [ADVANCE_BITS-1:0] room_ext;
  logic [39:0]             year_ext;
  logic [FoldW-1:0]        fold_a;
  logic [10:0]             fold_t;
  logic [8:0]              fold_u;
  logic [MonthW-1:0]       ld_month;
  logic [DoyW-1:0]         doy;

  assign leap     = leap_of_rem(rem_q, year_q[3:0]);
  assign mlen     = month_len(month_q, leap);
  assign room     = mlen - day_q;
  assign room_ext = {{(ADVANCE_BITS-DayW){1'b0}}, room};

  // Year modulo 25: 1024 counts as -1, then 32 counts as 7.
  assign year_ext = {{(40-YEAR_BITS){1'b0}}, year_q};
  assign fold_a   = FoldBias + FoldW'(year_ext[9:0]) + FoldW'(year_ext[29:20]) -
                    FoldW'(year_ext[19:10]) - FoldW'(year_ext[39:30]);
  assign fold_t   = {1'b0, fold_q[9:0]} + 11'd25 - {8'b0, fold_q[12:10]};
  assign fold_u   = {fold_t[10:5], 3'b000} - {3'b000, fold_t[10:5]} +
                    {4'b0000, fold_t[4:0]};

  always_comb begin
    if (load_month_i == '0) begin
      ld_month = MonthJan;
    end else if (load_month_i > MonthDec) begin
      ld_month = MonthDec;
    end else begin
      ld_month = load_month_i;
    end
  end

  assign sts_o.mod_last = (cnt_q == '0);
  assign sts_o.adv_last = (n_q <= room_ext);

  always_comb begin
    month_d = month_q;
    day_d   = day_q;
    year_d  = year_q;
    rem_d   = rem_q;
    fold_d  = fold_q;
    cnt_d   = cnt_q;
    n_d     = n_q;
    if (cmd_i.load) begin
      month_d = ld_month;
      day_d   = (load_day_i == '0) ? DayFirst : load_day_i;
      year_d  = load_year_i;
      rem_d   = '0;
      cnt_d   = CntStart;
      n_d     = advance_days_i;
    end else if (cmd_i.adv_start) begin
      n_d     = advance_days_i;
    end else if (cmd_i.mod_step) begin
      // Fold the year, fold again, then reduce the byte that is left.
      case (cnt_q)
        2'd2:    fold_d = fold_a;
        2'd1:    fold_d = FoldW'(fold_u);
        default: rem_d  = mod25_byte(fold_q[7:0]);
      endcase
      cnt_d = cnt_q - 1'b1;
    end else if (cmd_i.clamp) begin
      if (day_q > mlen) begin
        day_d = mlen;
      end
    end else if (cmd_i.adv_step) begin
      if (n_q <= room_ext) begin
        day_d = day_q + n_q[DayW-1:0];
        n_d   = '0;
      end else begin
        n_d   = n_q - room_ext - 1'b1;
        day_d = DayFirst;
        if (month_q >= MonthDec) begin
          month_d = MonthJan;
          year_d  = year_q + 1'b1;
          // Wrap to year zero restarts the 25-year cycle.
          rem_d   = ((year_q == '1) || (rem_q == Rem24)) ? '0 : rem_q + 1'b1;
        end else begin
          month_d = month_q + 1'b1;
        end
      end
    end
  end

  // Held date resets to January 1 of year zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      month_q <= MonthJan;
      day_q   <= DayFirst;
      year_q  <= '0;
      rem_q   <= '0;
      cnt_q   <= '0;
    end else begin
      month_q <= month_d;
      day_q   <= day_d;
      year_q  <= year_d;
      rem_q   <= rem_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fold_q <= fold_d;
    n_q    <= n_d;
  end

  assign doy = days_before(month_q) + DoyW'(day_q) +
               DoyW'(leap && (month_q > MonthFeb));

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cur_month_o   <= month_q;
      cur_day_o     <= day_q;
      cur_year_o    <= year_q;
      leap_flag_o   <= leap;
      day_of_year_o <= doy;
      days_left_o   <= (leap ? LeapYearLen : YearLen) - doy;
    end
  end

endmodule

// ----- hdl/cda_ctrl.sv -----
// Controller of the date counter: sequences load, advance and result hand-off.
module cda_ctrl
  import cda_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     in_advance_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output cda_cmd_t cmd_o,
  input  cda_sts_t sts_i
);

  typedef enum logic [2:0] {
    StIdle,
    StMod,
    StClamp,
    StAdv,
    StResult
  } state_e;

  state_e state_q;
  logic   accept;
  logic   slot_free;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_o || out_ready_i;

  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = accept && !in_advance_i;
    cmd_o.adv_start = accept && in_advance_i;
    cmd_o.mod_step  = (state_q == StMod);
    cmd_o.clamp     = (state_q == StClamp);
    cmd_o.adv_step  = (state_q == StAdv);
    cmd_o.capture   = (state_q == StResult) && slot_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_o <= 1'b0;
    end else begin
      if (cmd_o.capture) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (accept) begin
            state_q <= in_advance_i ? StAdv : StMod;
          end
        end
        StMod: begin
          if (sts_i.mod_last) begin
            state_q <= StClamp;
          end
        end
        StClamp: begin
          state_q <= StResult;
        end
        StAdv: begin
          if (sts_i.adv_last) begin
            state_q <= StResult;
          end
        end
        StResult: begin
          if (slot_free) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

// ----- hdl/calendar_date_advance.sv -----
// Top level of the Gregorian date counter: stream ports, controller and datapath.
//
// Holds a Gregorian date (month, day, year) and answers every request with one
// result: the date, a leap flag, the day of the year and the days left in the
// year. A request with tuser = 0 loads a date: a month of 0 becomes January and
// one above 12 December, a day of 0 becomes the 1st and one past the month end
// the last day of that month. After acceptance, three steps fold the year modulo
// 25 for the leap test, one fits the day into its month and one latches the
// result. A request with tuser = 1 advances the date by advance_days; the advance
// moves one calendar month per cycle, and one more step latches the result. The
// year wraps modulo 2^YEAR_BITS, and year 0 counts as a leap year. One request
// is worked on at a time; the result sits in an output register, and the next
// request is taken in the cycle after the previous result has been latched
// there. A stalled result does not block new requests, but the next result
// waits to be latched until it leaves.
module calendar_date_advance
  import cda_pkg::*;
#(
  parameter int unsigned YEAR_BITS    = 16,
  parameter int unsigned ADVANCE_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // load_month[3:0], load_day, load_year, advance_days, zero padding
  input  logic [((MonthW + DayW + YEAR_BITS + ADVANCE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata_i,
  // operation (0 load, 1 advance)
  input  logic [0:0]          s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // cur_month[3:0], cur_day, cur_year, leap_flag, day_of_year, days_left, padding
  output logic [((MonthW + DayW + YEAR_BITS + 1 + 2 * DoyW + 7) / 8) * 8 - 1:0] m_axis_tdata_o
);

  localparam int unsigned InBits  = MonthW + DayW + YEAR_BITS + ADVANCE_BITS;
  localparam int unsigned OutBits = MonthW + DayW + YEAR_BITS + 1 + 2 * DoyW;
  localparam int unsigned OutW    = ((OutBits + 7) / 8) * 8;

  cda_cmd_t cmd;
  cda_sts_t sts;

  logic [MonthW-1:0]       cur_month;
  logic [DayW-1:0]         cur_day;
  logic [YEAR_BITS-1:0]    cur_year;
  logic                    leap_flag;
  logic [DoyW-1:0]         day_of_year;
  logic [DoyW-1:0]         days_left;

  // Sequence each request: accept, iterate, latch the result.
  cda_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_advance_i (s_axis_tuser_i[0]),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .cmd_o        (cmd),
    .sts_i        (sts)
  );

  // Hold the date and work out the result fields.
  cda_datapath #(
    .YEAR_BITS    (YEAR_BITS),
    .ADVANCE_BITS (ADVANCE_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .load_month_i   (s_axis_tdata_i[MonthW-1:0]),
    .load_day_i     (s_axis_tdata_i[MonthW+DayW-1:MonthW]),
    .load_year_i    (s_axis_tdata_i[MonthW+DayW+YEAR_BITS-1:MonthW+DayW]),
    .advance_days_i (s_axis_tdata_i[InBits-1:MonthW+DayW+YEAR_BITS]),
    .cur_month_o    (cur_month),
    .cur_day_o      (cur_day),
    .cur_year_o     (cur_year),
    .leap_flag_o    (leap_flag),
    .day_of_year_o  (day_of_year),
    .days_left_o    (days_left)
  );

  // Pack the result fields, lowest field in the lowest bits.
  assign m_axis_tdata_o = OutW'({days_left, day_of_year, leap_flag, cur_year,
                                 cur_day, cur_month});

endmodule

// ----- dv/cda_tb_pkg.sv -----
// Request and result layouts and operation codes shared by the date counter bench.
package cda_tb_pkg;

  localparam int unsigned YearW = 16;
  localparam int unsigned AdvW  = 16;

  typedef enum logic [0:0] {
    OpLoad    = 1'b0,
    OpAdvance = 1'b1
  } date_op_e;

  // tdata of a request, lowest field last in the list
  typedef struct packed {
    logic [6:0]      pad;
    logic [AdvW-1:0] advance_days;
    logic [YearW-1:0] load_year;
    logic [4:0]      load_day;
    logic [3:0]      load_month;
  } date_req_t;

  // tdata of a result, lowest field last in the list
  typedef struct packed {
    logic [3:0]       pad;
    logic [8:0]       days_left;
    logic [8:0]       day_of_year;
    logic             leap_flag;
    logic [YearW-1:0] cur_year;
    logic [4:0]       cur_day;
    logic [3:0]       cur_month;
  } date_res_t;

endpackage

// ----- dv/calendar_date_advance_checker.sv -----
// Checker of the date counter: tracks the held date and compares every result.
module calendar_date_advance_checker
  import cda_pkg::*;
  import cda_tb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  // load_month, load_day, load_year, advance_days, padding
  input  date_req_t   s_axis_tdata_i,
  // operation
  input  logic [0:0]  s_axis_tuser_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  // cur_month, cur_day, cur_year, leap_flag, day_of_year, days_left, padding
  input  date_res_t   m_axis_tdata_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  logic [MonthW-1:0] held_month;
  logic [DayW-1:0]   held_day;
  logic [YearW-1:0]  held_year;
  date_res_t         due_dates_q[$];

  function automatic logic year_is_leap(input logic [YearW-1:0] y);
    int unsigned v;
    v = y;
    return (v % 4 == 0) && ((v % 400 == 0) || (v % 100 != 0));
  endfunction

  function automatic int unsigned days_in_month(input int unsigned m,
                                                input logic [YearW-1:0] y);
    int unsigned len;
    case (m)
      MonthFeb:        len = year_is_leap(y) ? 29 : 28;
      4, 6, 9, 11:     len = 30;
      default:         len = 31;
    endcase
    return len;
  endfunction

  // Apply one request to the held date and return the date it reports.
  function automatic date_res_t step_calendar(input date_op_e op, input date_req_t req);
    date_res_t   res;
    int unsigned m;
    int unsigned d;
    int unsigned n;
    int unsigned room;
    int unsigned doy;
    int unsigned ylen;
    if (op == OpLoad) begin
      m = req.load_month;
      if (m < MonthJan) m = MonthJan;
      if (m > MonthDec) m = MonthDec;
      d = req.load_day;
      if (d < DayFirst) d = DayFirst;
      if (d > days_in_month(m, req.load_year)) d = days_in_month(m, req.load_year);
      held_month = m[MonthW-1:0];
      held_day   = d[DayW-1:0];
      held_year  = req.load_year;
    end else begin
      n = req.advance_days;
      while (n > 0) begin
        room = days_in_month(held_month, held_year) - held_day;
        if (n <= room) begin
          held_day = held_day + n[DayW-1:0];
          n = 0;
        end else begin
          n = n - (room + 1);
          held_day = DayFirst;
          if (held_month >= MonthDec) begin
            held_month = MonthJan;
            held_year  = held_year + 1'b1;
          end else begin
            held_month = held_month + 1'b1;
          end
        end
      end
    end
    doy = held_day;
    for (int unsigned k = 1; k < held_month; k++) doy += days_in_month(k, held_year);
    ylen = year_is_leap(held_year) ? 366 : 365;
    res             = '0;
    res.cur_month   = held_month;
    res.cur_day     = held_day;
    res.cur_year    = held_year;
    res.leap_flag   = year_is_leap(held_year);
    res.day_of_year = doy[8:0];
    res.days_left   = 9'(ylen - doy);
    return res;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    date_res_t due;
    if (!rst_ni) begin
      held_month   = MonthJan;
      held_day     = DayFirst;
      held_year    = '0;
      fail_count_o = 0;
      due_dates_q.delete();
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        due_dates_q.push_back(step_calendar(date_op_e'(s_axis_tuser_i), s_axis_tdata_i));
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (due_dates_q.size() == 0) begin
          $error("result %h with no request outstanding", m_axis_tdata_i);
          fail_count_o++;
        end else begin
          due = due_dates_q.pop_front();
          check_field("cur_month", due.cur_month, m_axis_tdata_i.cur_month);
          check_field("cur_day", due.cur_day, m_axis_tdata_i.cur_day);
          check_field("cur_year", due.cur_year, m_axis_tdata_i.cur_year);
          check_field("leap_flag", due.leap_flag, m_axis_tdata_i.leap_flag);
          check_field("day_of_year", due.day_of_year, m_axis_tdata_i.day_of_year);
          check_field("days_left", due.days_left, m_axis_tdata_i.days_left);
        end
      end
    end
    pending_o = due_dates_q.size();
  end

endmodule

// ----- dv/calendar_date_advance_tb.sv -----
// Bench top of the date counter: clock, reset, request stimulus and verdict.
module calendar_date_advance_tb;
  import cda_pkg::*;
  import cda_tb_pkg::*;

  localparam int unsigned ClkPeriod      = 12;
  localparam int unsigned ResetCycles    = 5;
  localparam int unsigned RandomPerPhase = 100;
  // run-on once no result is outstanding; allow a good margin
  localparam int unsigned DrainCycles    = 64;
  // bound on the run, sized for the longest advances plus stalls
  localparam int unsigned TimeoutCycles  = 1_000_000;

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  date_req_t   s_axis_tdata  = '0;
  logic [0:0]  s_axis_tuser  = OpLoad;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  date_res_t   m_axis_tdata;

  int unsigned fail_count;
  int unsigned pending;

  // percentage of cycles in which the sender holds off or the receiver stalls
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;

  always #(ClkPeriod / 2) clk = ~clk;

  calendar_date_advance #(
    .YEAR_BITS   (YearW),
    .ADVANCE_BITS(AdvW)
  ) DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata)
  );

  calendar_date_advance_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_i(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tvalid_i(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_i (m_axis_tdata),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // Stall the result side at random, one decision per cycle.
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Present one request, hold it until accepted, and return at the accepting edge.
  task automatic send_request(input date_op_e op, input logic [3:0] month,
                              input logic [4:0] day, input logic [YearW-1:0] year,
                              input logic [AdvW-1:0] adv);
    date_req_t req;
    req              = '0;
    req.load_month   = month;
    req.load_day     = day;
    req.load_year    = year;
    req.advance_days = adv;
    // hold off the sender for a random gap
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= req;
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Draw a random request; the fields not used by the operation carry noise.
  task automatic send_random_request();
    date_op_e          op;
    logic [3:0]        month;
    logic [4:0]        day;
    logic [YearW-1:0]  year;
    logic [AdvW-1:0]   adv;
    op    = ($urandom_range(99) < 30) ? OpLoad : OpAdvance;
    // mostly valid months, now and then out of range ones
    month = ($urandom_range(99) < 80) ? 4'($urandom_range(1, 12)) : 4'($urandom_range(0, 15));
    day   = 5'($urandom_range(0, 31));
    case ($urandom_range(3))
      0:       year = 16'($urandom);
      1:       year = 16'($urandom_range(0, 655) * 100);
      2:       year = 16'(65535 - $urandom_range(0, 2));
      default: year = 16'($urandom_range(0, 16383) * 4);
    endcase
    // keep advances short on the whole, with a few of full width
    case ($urandom_range(99)) inside
      [0:59]:  adv = 16'($urandom_range(0, 40));
      [60:89]: adv = 16'($urandom_range(0, 400));
      [90:97]: adv = 16'($urandom_range(0, 3000));
      default: adv = 16'($urandom);
    endcase
    send_request(op, month, day, year, adv);
  endtask

  initial begin
    // Hold reset low at the start, then release it once.
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, with no idling on either side.
    send_request(OpAdvance, 4'd0, 5'd0, 16'd0, 16'd0);         // reset date, no move
    send_request(OpLoad, 4'd0, 5'd0, 16'd2000, 16'd0);         // month and day of zero
    send_request(OpLoad, 4'd13, 5'd31, 16'd1999, 16'd0);       // month above December
    send_request(OpAdvance, 4'hF, 5'h1F, 16'hFFFF, 16'd1);     // into a new century
    send_request(OpLoad, 4'd15, 5'd31, 16'hFFFF, 16'hFFFF);    // last day of the last year
    send_request(OpAdvance, 4'hF, 5'h1F, 16'hFFFF, 16'd1);     // year wraps to zero
    send_request(OpLoad, 4'd2, 5'd29, 16'd1900, 16'd0);        // century, common year
    send_request(OpLoad, 4'd2, 5'd31, 16'd2000, 16'd0);        // four centuries, leap
    send_request(OpLoad, 4'd4, 5'd31, 16'd2023, 16'd0);        // day past a 30-day month
    send_request(OpLoad, 4'd2, 5'd28, 16'd2024, 16'd0);
    send_request(OpAdvance, 4'd0, 5'd0, 16'd0, 16'd1);         // onto the leap day
    send_request(OpAdvance, 4'd0, 5'd0, 16'd0, 16'd1);         // and off it
    send_request(OpLoad, 4'd12, 5'd31, 16'd2024, 16'd0);       // day 366, none left
    send_request(OpLoad, 4'd1, 5'd1, 16'd2100, 16'd0);
    send_request(OpAdvance, 4'd0, 5'd0, 16'd0, 16'd59);        // across a common February
    send_request(OpLoad, 4'd1, 5'd31, 16'd2023, 16'd0);
    send_request(OpAdvance, 4'd0, 5'd0, 16'd0, 16'd31);        // from a month end across February
    send_request(OpLoad, 4'd6, 5'd15, 16'd2400, 16'd0);
    send_request(OpAdvance, 4'd0, 5'd0, 16'd0, 16'd365);       // close to a whole year
    send_request(OpAdvance, 4'd0, 5'd0, 16'd0, 16'hFFFF);      // largest advance
    send_request(OpLoad, 4'd1, 5'd1, 16'd0, 16'd0);            // year zero is leap
    send_request(OpAdvance, 4'd0, 5'd0, 16'd0, 16'd0);

    // Random part in four idling phases.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 68;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 68;
        end
        default: begin
          idle_pct  = 16;
          stall_pct = 16;
        end
      endcase
      repeat (RandomPerPhase) send_random_request();
    end

    // Drop the request line and let the last results drain.
    s_axis_tvalid <= 1'b0;
    stall_pct = 0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // End a run that hangs.
  initial begin
    #(ClkPeriod * TimeoutCycles);
    $display("FAILURE");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/cda_pkg.sv
hdl/cda_datapath.sv
hdl/cda_ctrl.sv
hdl/calendar_date_advance.sv
dv/cda_tb_pkg.sv
dv/calendar_date_advance_checker.sv
dv/calendar_date_advance_tb.sv
